@@ rtl/lome_pkg.sv @@
`timescale 1ns / 1ps
package lome_pkg;

  // Default sizing of the order book.
  localparam int BOOK_DEPTH_DEF      = 32;
  localparam int NUM_STOCK_BOOKS_DEF = 16;
  localparam int NUM_TRADER_IDS_DEF  = 256;

  // Field widths of the order and result items.
  localparam int PRICE_W  = 16;
  localparam int QTY_W    = 16;
  localparam int TRADER_W = 8;
  localparam int STOCK_W  = 4;
  localparam int SEQ_W    = 32;
  localparam int TRD_CFG_W = 9;
  localparam int STK_CFG_W = 5;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic CFG_TRADERS = 1'b0;
  localparam logic CFG_STOCKS  = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_TRADE    = 2'd0,
    KIND_RESTED   = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_DROPPED  = 2'd3
  } lome_kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_FREE,
    ST_PLACE
  } lome_state_t;

  // One resting order as stored in the book memory.
  typedef struct packed {
    logic                valid;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
    logic [TRADER_W-1:0] trader;
    logic [SEQ_W-1:0]    seq;
  } lome_entry_t;

  localparam int ENTRY_W = $bits(lome_entry_t);

endpackage

@@ rtl/lome_ram.sv @@
`timescale 1ns / 1ps
module lome_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lome_best.sv @@
`timescale 1ns / 1ps
module lome_best
  import lome_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          sample,
  input  lome_entry_t                   entry,
  input  logic [$clog2(BOOK_DEPTH)-1:0] slot,
  input  logic                          side,
  input  logic [PRICE_W-1:0]            limit,
  output logic                          found,
  output lome_entry_t                   best,
  output logic [$clog2(BOOK_DEPTH)-1:0] best_slot
);

  localparam int SW = $clog2(BOOK_DEPTH);

  logic          found_r, found_nxt;
  lome_entry_t   best_r, best_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          crosses, better;

  // Compare unit: does this entry cross the limit, and does it beat
  // the best one seen so far on price, then on age.
  always_comb begin
    crosses = side ? (entry.price >= limit) : (entry.price <= limit);
    if (!found_r) begin
      better = 1'b1;
    end else if (entry.price == best_r.price) begin
      better = entry.seq < best_r.seq;
    end else begin
      better = side ? (entry.price > best_r.price) : (entry.price < best_r.price);
    end
  end

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    slot_nxt  = slot_r;
    if (clear) begin
      found_nxt = 1'b0;
    end else if (sample && entry.valid && crosses && better) begin
      found_nxt = 1'b1;
      best_nxt  = entry;
      slot_nxt  = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_r <= best_nxt;
    slot_r <= slot_nxt;
  end

  assign found     = found_r;
  assign best      = best_r;
  assign best_slot = slot_r;

endmodule

@@ rtl/limit_order_matching_engine.sv @@
`timescale 1ns / 1ps
// Limit order matching engine with price-time priority. An order item is
// taken when start is high and busy is low; its results follow one at a time,
// each held on the out_ ports for a single cycle with out_valid high and with
// out_last on the final one, and must be taken as they come since the
// receiver cannot stall them. Each search of the opposite side walks its
// BOOK_DEPTH slots through the single read port of the book memory before
// the fill that follows; a remainder takes one more walk to find a free slot
// on its own side before it rests or is dropped, and goes to that walk without
// a further search once it has had BOOK_DEPTH fills. A malformed order is
// rejected with no search. After reset the book memory is cleared one entry
// per cycle, all NUM_STOCK_BOOKS * 2 * BOOK_DEPTH entries, during which busy
// stays high; configuration writes are always taken.
module limit_order_matching_engine
  import lome_pkg::*;
#(
  parameter int BOOK_DEPTH      = BOOK_DEPTH_DEF,
  parameter int NUM_STOCK_BOOKS = NUM_STOCK_BOOKS_DEF,
  parameter int NUM_TRADER_IDS  = NUM_TRADER_IDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_side,
  input  logic [TRADER_W-1:0]   in_trader_id,
  input  logic [STOCK_W-1:0]    in_stock_id,
  input  logic [PRICE_W-1:0]    in_limit_price,
  input  logic [QTY_W-1:0]      in_order_quantity,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [TRADER_W-1:0]   out_buyer_id,
  output logic [TRADER_W-1:0]   out_seller_id,
  output logic [STOCK_W-1:0]    out_fill_stock,
  output logic [PRICE_W-1:0]    out_fill_price,
  output logic [QTY_W-1:0]      out_fill_quantity,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TOTAL = NUM_STOCK_BOOKS * 2 * BOOK_DEPTH;
  localparam int AW    = $clog2(TOTAL);
  localparam int SW    = $clog2(BOOK_DEPTH);
  localparam int CW    = $clog2(BOOK_DEPTH + 1);

  lome_state_t state_r, state_nxt;

  logic [TRD_CFG_W-1:0] traders_r;
  logic [STK_CFG_W-1:0] stocks_r;

  logic                side_r, side_nxt;
  logic [TRADER_W-1:0] trader_r, trader_nxt;
  logic [STOCK_W-1:0]  stock_r, stock_nxt;
  logic [PRICE_W-1:0]  price_r, price_nxt;
  logic [QTY_W-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]       nfill_r, nfill_nxt;
  logic [AW-1:0]       opp_base_r, opp_base_nxt;
  logic [AW-1:0]       own_base_r, own_base_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SW-1:0]       rd_slot_r, rd_slot_nxt;
  logic                free_found_r, free_found_nxt;
  logic [SW-1:0]       free_slot_r, free_slot_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;

  logic                out_valid_r, out_valid_nxt;
  lome_kind_t          out_kind_r, out_kind_nxt;
  logic [TRADER_W-1:0] out_buyer_r, out_buyer_nxt;
  logic [TRADER_W-1:0] out_seller_r, out_seller_nxt;
  logic [STOCK_W-1:0]  out_stock_r, out_stock_nxt;
  logic [PRICE_W-1:0]  out_price_r, out_price_nxt;
  logic [QTY_W-1:0]    out_qty_r, out_qty_nxt;
  logic                out_last_r, out_last_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  lome_entry_t   mem_wdata, mem_rdata;

  logic          best_clear, best_sample, best_found;
  lome_entry_t   best;
  logic [SW-1:0] best_slot;

  logic          accept, order_bad;
  logic [QTY_W-1:0] fill;
  logic [AW-1:0] in_opp_base, in_own_base;

  lome_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOTAL)
  ) u_book (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lome_best #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (best_clear),
    .sample    (best_sample),
    .entry     (mem_rdata),
    .slot      (rd_slot_r),
    .side      (side_r),
    .limit     (price_r),
    .found     (best_found),
    .best      (best),
    .best_slot (best_slot)
  );

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      traders_r <= TRD_CFG_W'(NUM_TRADER_IDS_DEF);
      stocks_r  <= STK_CFG_W'(NUM_STOCK_BOOKS_DEF);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRADERS: traders_r <= cfg_data;
        CFG_STOCKS:  stocks_r  <= cfg_data[STK_CFG_W-1:0];
        default:     ;
      endcase
    end
  end

  // Order screening and book base addresses.
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign order_bad = ({1'b0, in_trader_id} >= traders_r) ||
                     (32'(in_trader_id) >= 32'(NUM_TRADER_IDS)) ||
                     ({1'b0, in_stock_id} >= stocks_r) ||
                     (32'(in_stock_id) >= 32'(NUM_STOCK_BOOKS)) ||
                     (in_limit_price == '0) || (in_order_quantity == '0);
  assign in_opp_base = AW'({in_stock_id, ~in_side}) * AW'(BOOK_DEPTH);
  assign in_own_base = AW'({in_stock_id, in_side}) * AW'(BOOK_DEPTH);

  assign fill = (best.qty < rem_r) ? best.qty : rem_r;

  // Sequencer: next state, memory port and result.
  always_comb begin
    state_nxt      = state_r;
    side_nxt       = side_r;
    trader_nxt     = trader_r;
    stock_nxt      = stock_r;
    price_nxt      = price_r;
    rem_nxt        = rem_r;
    nfill_nxt      = nfill_r;
    opp_base_nxt   = opp_base_r;
    own_base_nxt   = own_base_r;
    seq_nxt        = seq_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_slot_nxt    = cnt_r[SW-1:0];
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    clr_addr_nxt   = clr_addr_r;
    best_clear     = 1'b0;
    best_sample    = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = '0;
    mem_raddr      = opp_base_r + AW'(cnt_r[SW-1:0]);
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = KIND_TRADE;
    out_buyer_nxt  = '0;
    out_seller_nxt = '0;
    out_stock_nxt  = stock_r;
    out_price_nxt  = '0;
    out_qty_nxt    = '0;
    out_last_nxt   = 1'b0;

    unique case (state_r)
      // Empty the book one entry per cycle.
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take an order; reject it at once if it is malformed.
      ST_IDLE: begin
        if (accept) begin
          if (order_bad) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REJECTED;
            out_stock_nxt = in_stock_id;
            out_last_nxt  = 1'b1;
          end else begin
            side_nxt     = in_side;
            trader_nxt   = in_trader_id;
            stock_nxt    = in_stock_id;
            price_nxt    = in_limit_price;
            rem_nxt      = in_order_quantity;
            nfill_nxt    = '0;
            opp_base_nxt = in_opp_base;
            own_base_nxt = in_own_base;
            cnt_nxt      = '0;
            best_clear   = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end

      // Walk the opposite side, one read per cycle, keeping the best entry.
      ST_SCAN: begin
        best_sample = rd_vld_r;
        if (cnt_r != CW'(BOOK_DEPTH)) begin
          cnt_nxt    = cnt_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_FILL;
        end
      end

      // Trade against the best entry and write it back, or look for a free slot when none crosses.
      ST_FILL: begin
        if (!best_found) begin
          cnt_nxt        = '0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_FREE;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = opp_base_r + AW'(best_slot);
          mem_wdata       = best;
          mem_wdata.qty   = best.qty - fill;
          mem_wdata.valid = (best.qty != fill);
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_TRADE;
          out_buyer_nxt   = side_r ? best.trader : trader_r;
          out_seller_nxt  = side_r ? trader_r : best.trader;
          out_price_nxt   = best.price;
          out_qty_nxt     = fill;
          out_last_nxt    = (rem_r == fill);
          rem_nxt         = rem_r - fill;
          nfill_nxt       = nfill_r + 1'b1;
          cnt_nxt         = '0;
          best_clear      = 1'b1;
          if (rem_r == fill) begin
            state_nxt = ST_IDLE;
          end else if (nfill_r == CW'(BOOK_DEPTH - 1)) begin
            free_found_nxt = 1'b0;
            state_nxt      = ST_FREE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // Find the lowest free slot on the order's own side.
      ST_FREE: begin
        mem_raddr = own_base_r + AW'(cnt_r[SW-1:0]);
        if (rd_vld_r && !mem_rdata.valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = rd_slot_r;
        end
        if (cnt_r != CW'(BOOK_DEPTH) && !free_found_r) begin
          cnt_nxt    = cnt_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_PLACE;
        end
      end

      // Rest the remainder, or drop it when the side is full.
      ST_PLACE: begin
        out_valid_nxt = 1'b1;
        out_price_nxt = price_r;
        out_qty_nxt   = rem_r;
        out_last_nxt  = 1'b1;
        if (free_found_r) begin
          mem_we           = 1'b1;
          mem_waddr        = own_base_r + AW'(free_slot_r);
          mem_wdata.valid  = 1'b1;
          mem_wdata.price  = price_r;
          mem_wdata.qty    = rem_r;
          mem_wdata.trader = trader_r;
          mem_wdata.seq    = seq_r;
          seq_nxt          = seq_r + 1'b1;
          out_kind_nxt     = KIND_RESTED;
        end else begin
          out_kind_nxt = KIND_DROPPED;
        end
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      seq_r        <= '0;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      seq_r        <= seq_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    side_r       <= side_nxt;
    trader_r     <= trader_nxt;
    stock_r      <= stock_nxt;
    price_r      <= price_nxt;
    rem_r        <= rem_nxt;
    nfill_r      <= nfill_nxt;
    opp_base_r   <= opp_base_nxt;
    own_base_r   <= own_base_nxt;
    rd_slot_r    <= rd_slot_nxt;
    free_slot_r  <= free_slot_nxt;
    out_kind_r   <= out_kind_nxt;
    out_buyer_r  <= out_buyer_nxt;
    out_seller_r <= out_seller_nxt;
    out_stock_r  <= out_stock_nxt;
    out_price_r  <= out_price_nxt;
    out_qty_r    <= out_qty_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_buyer_id      = out_buyer_r;
  assign out_seller_id     = out_seller_r;
  assign out_fill_stock    = out_stock_r;
  assign out_fill_price    = out_price_r;
  assign out_fill_quantity = out_qty_r;
  assign out_last          = out_last_r;

endmodule
